// File: sv/kmsam_pkg.sv
// ---------------------------------------------------------------------------
// kmsam_pkg
// Shared types and constants for the k-mer minimiser sampler.
// ---------------------------------------------------------------------------
package kmsam_pkg;

   localparam int SYM_BITS          = 2;
   localparam int KMER_LEN_BITS     = 6;
   localparam int WIN_LEN_BITS      = 7;
   localparam int CSR_DATA_BITS     = 7;
   localparam int KMER_VALUE_BITS   = 64;
   localparam int POS_OUT_BITS      = 32;

   // default parameter values
   localparam int DEF_MAX_KMER      = 32;
   localparam int DEF_WINDOW_DEPTH  = 64;
   localparam int DEF_POSITION_BITS = 32;

   // register indexes
   localparam logic CSR_KMER_LENGTH   = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   // register reset values
   localparam logic [KMER_LEN_BITS-1:0] KMER_LEN_RESET = 6'd15;
   localparam logic [WIN_LEN_BITS-1:0]  WIN_LEN_RESET  = 7'd32;

   typedef struct packed {
      logic [SYM_BITS-1:0] symbol;
      logic                sequence_end;
   } req_type;

   typedef struct packed {
      logic [KMER_VALUE_BITS-1:0] kmer_value;
      logic                       from_complement;
      logic [POS_OUT_BITS-1:0]    kmer_position;
   } rsp_type;

   // cell chain control
   typedef struct packed {
      logic push;   // shift a new symbol into the store chain
      logic load;   // copy the store chain into the scan chain
      logic step;   // move the scan chain one cell towards cell 0
   } ctrl_type;

endpackage

// File: sv/kmsam_cell.sv
// ---------------------------------------------------------------------------
// kmsam_cell
// One cell of the symbol chain: a stored symbol and a scan copy of it.
// ---------------------------------------------------------------------------
module kmsam_cell (
   input  logic                          clock,
   input  kmsam_pkg::ctrl_type           ctrl,
   input  logic [kmsam_pkg::SYM_BITS-1:0] sym_in,
   input  logic [kmsam_pkg::SYM_BITS-1:0] scan_in,
   output logic [kmsam_pkg::SYM_BITS-1:0] sym_out,
   output logic [kmsam_pkg::SYM_BITS-1:0] scan_out
);

   logic [kmsam_pkg::SYM_BITS-1:0] sym_ff;
   logic [kmsam_pkg::SYM_BITS-1:0] scan_ff;

   // store: newer symbol comes from the neighbour on the low side
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         sym_ff <= sym_in;
      end
   end

   // scan copy: loaded in parallel, then walks towards cell 0
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         scan_ff <= sym_ff;
      end else if (ctrl.step) begin
         scan_ff <= scan_in;
      end
   end

   assign sym_out  = sym_ff;
   assign scan_out = scan_ff;

endmodule

// File: sv/kmer_minimizer_sampler.sv
// ---------------------------------------------------------------------------
// kmer_minimizer_sampler
// Streaming (w,k) minimiser sampler over 2-bit symbols, built on a chain of
// symbol cells that is copied and walked to find the smallest k-mer.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_ready | req_data (symbol, sequence_end)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (value, strand, position)
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
//  A symbol with no result goes through accept and then the window check.
//  A symbol that closes a window goes on to skip the d symbols past the
//  window end (normally 0), then walks the scan chain one k-mer per cycle,
//  then issues its result once the output register can take it.
//  Synchronous reset clears control state; the symbol cells hold no reset.
//  A result waits in the output register; the sampler stalls only when a
//  second result is ready before the first is taken.
// ---------------------------------------------------------------------------
module kmer_minimizer_sampler #(
   parameter int MAX_KMER      = kmsam_pkg::DEF_MAX_KMER,
   parameter int WINDOW_DEPTH  = kmsam_pkg::DEF_WINDOW_DEPTH,
   parameter int POSITION_BITS = kmsam_pkg::DEF_POSITION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  kmsam_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output kmsam_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [kmsam_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SB       = kmsam_pkg::SYM_BITS;
   localparam int KB       = kmsam_pkg::KMER_LEN_BITS;
   localparam int WB       = $clog2(WINDOW_DEPTH + 1);
   localparam int PB       = POSITION_BITS;
   localparam int KLIM     = (MAX_KMER < WINDOW_DEPTH) ? MAX_KMER : WINDOW_DEPTH;
   localparam int VB       = SB * MAX_KMER;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // registers
   logic [1:0]         state_ff, state_in;
   logic [PB-1:0]      seen_ff, seen_in;
   logic [PB-1:0]      ws_ff, ws_in;
   logic               last_ff, last_in;
   logic [WB-1:0]      skip_ff, skip_in;
   logic [WB-1:0]      cnt_ff, cnt_in;
   logic [PB-1:0]      pos_ff, pos_in;
   logic [VB-1:0]      best_t_ff, best_t_in;
   logic [VB-1:0]      best_c_ff, best_c_in;
   logic [PB-1:0]      pos_t_ff, pos_t_in;
   logic [PB-1:0]      pos_c_ff, pos_c_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kmsam_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [KB-1:0]      klen_ff;
   logic [kmsam_pkg::WIN_LEN_BITS-1:0] wlen_ff;

   kmsam_pkg::ctrl_type ctrl;

   logic [SB-1:0] sym_q  [WINDOW_DEPTH];
   logic [SB-1:0] scan_q [WINDOW_DEPTH];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= kmsam_pkg::KMER_LEN_RESET;
         wlen_ff <= kmsam_pkg::WIN_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kmsam_pkg::CSR_KMER_LENGTH:   klen_ff <= csr_wdata[KB-1:0];
            kmsam_pkg::CSR_WINDOW_LENGTH: wlen_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective k and w
   logic [KB-1:0] k_eff;
   logic [WB-1:0] w_clip, w_eff;
   always_comb begin
      if (klen_ff == '0) begin
         k_eff = KB'(1);
      end else if (int'(klen_ff) > KLIM) begin
         k_eff = KB'(KLIM);
      end else begin
         k_eff = klen_ff;
      end
      if (wlen_ff == '0) begin
         w_clip = WB'(1);
      end else if (int'(wlen_ff) > WINDOW_DEPTH) begin
         w_clip = WB'(WINDOW_DEPTH);
      end else begin
         w_clip = WB'(wlen_ff);
      end
      if (int'(w_clip) < int'(k_eff)) begin
         w_eff = WB'(k_eff);
      end else begin
         w_eff = w_clip;
      end
   end

   // k-mer mask, one symbol lane at a time
   logic [VB-1:0] kmask;
   always_comb begin
      for (int j = 0; j < MAX_KMER; j++) begin
         kmask[j*SB +: SB] = (j < int'(k_eff)) ? {SB{1'b1}} : {SB{1'b0}};
      end
   end

   // cell chain: cell 0 holds the newest symbol
   genvar g;
   generate
      for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
         logic [SB-1:0] sym_nb;
         logic [SB-1:0] scan_nb;
         if (g == 0) begin : g_head
            assign sym_nb = req_data.symbol;
         end else begin : g_body
            assign sym_nb = sym_q[g-1];
         end
         if (g == WINDOW_DEPTH - 1) begin : g_tail
            assign scan_nb = '0;
         end else begin : g_mid
            assign scan_nb = scan_q[g+1];
         end
         kmsam_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .sym_in   (sym_nb),
            .scan_in  (scan_nb),
            .sym_out  (sym_q[g]),
            .scan_out (scan_q[g])
         );
      end
   endgenerate

   // current k-mer at the low end of the scan chain; lanes past k are masked
   logic [VB-1:0] scan_vec, kv, kc;
   always_comb begin
      scan_vec = '0;
      for (int j = 0; j < KLIM; j++) begin
         scan_vec[j*SB +: SB] = scan_q[j];
      end
      kv = scan_vec & kmask;
      kc = ~scan_vec & kmask;
   end

   logic          accept;
   logic [PB-1:0] diff;
   logic          complete;
   logic          can_load;
   logic          pick_c;

   assign accept   = req_valid && req_ready;
   assign diff     = seen_ff - ws_ff;
   assign complete = diff >= PB'(w_eff);
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign pick_c   = best_t_ff > best_c_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      ws_in        = ws_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      best_t_in    = best_t_ff;
      best_c_in    = best_c_ff;
      pos_t_in     = pos_t_ff;
      pos_c_in     = pos_c_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_data.sequence_end;
               if (seen_ff != '1) begin
                  ctrl.push = 1'b1;
                  seen_in   = seen_ff + PB'(1);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (complete) begin
               ctrl.load = 1'b1;
               skip_in   = WB'(diff - PB'(w_eff));
               cnt_in    = w_eff - WB'(k_eff) + WB'(1);
               pos_in    = ws_ff + PB'(w_eff) - PB'(k_eff);
               best_t_in = '1;
               best_c_in = '1;
               state_in  = ST_SCAN;
            end else begin
               if (last_ff) begin
                  ws_in   = '0;
                  seen_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            ctrl.step = 1'b1;
            if (skip_ff != '0) begin
               skip_in = skip_ff - WB'(1);
            end else begin
               // walking backwards, so ties go to the earlier position
               if (kv <= best_t_ff) begin
                  best_t_in = kv;
                  pos_t_in  = pos_ff;
               end
               if (kc <= best_c_ff) begin
                  best_c_in = kc;
                  pos_c_in  = pos_ff;
               end
               pos_in = pos_ff - PB'(1);
               cnt_in = cnt_ff - WB'(1);
               if (cnt_ff == WB'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.kmer_value      = kmsam_pkg::KMER_VALUE_BITS'(
                                                pick_c ? best_c_ff : best_t_ff);
               rsp_data_in.from_complement = pick_c;
               rsp_data_in.kmer_position   = kmsam_pkg::POS_OUT_BITS'(
                                                pick_c ? pos_c_ff : pos_t_ff);
               ws_in = (pick_c ? pos_c_ff : pos_t_ff) + PB'(1);
               if (last_ff) begin
                  ws_in   = '0;
                  seen_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         ws_ff        <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         ws_ff        <= ws_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan payload registers
   always_ff @(posedge clock) begin
      skip_ff     <= skip_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      best_t_ff   <= best_t_in;
      best_c_ff   <= best_c_in;
      pos_t_ff    <= pos_t_in;
      pos_c_ff    <= pos_c_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted word not followed by window check");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff != '0)
      else $error("scan running with no k-mers left");

   a_start_order: assert property (@(posedge clock) disable iff (reset)
      ws_ff <= seen_ff)
      else $error("window start past symbol count");

endmodule
